@@ src/crp_pkg.sv @@
`timescale 1ns / 1ps
// shared constants for the catmull-rom point evaluator
// no dependencies

package crp_pkg;

  // headroom above the coordinate width for the horner accumulator
  localparam int unsigned AccGuardBits = 6;

  // number of axes evaluated in parallel (x and y)
  localparam int unsigned NumAxes = 2;

  // register stages from input to output
  localparam int unsigned PipeDepth = 8;

endpackage

@@ src/catmull_rom_point_eval_top.sv @@
`timescale 1ns / 1ps
// catmull-rom point evaluator, top level; uses crp_pkg, crp_coef, crp_step, crp_final
// path: coefficients, horner steps, halve and saturate, then result valid
// throughput: one request per cycle unless out_stall_i holds a finished result
// stall: the whole pipeline freezes while a finished result is held by out_stall_i
// reset: only the stage valid bits are cleared; data registers are not reset

module catmull_rom_point_eval_top #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned T_WIDTH     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] p0_x_i,
  input  logic signed [COORD_WIDTH-1:0] p0_y_i,
  input  logic signed [COORD_WIDTH-1:0] p1_x_i,
  input  logic signed [COORD_WIDTH-1:0] p1_y_i,
  input  logic signed [COORD_WIDTH-1:0] p2_x_i,
  input  logic signed [COORD_WIDTH-1:0] p2_y_i,
  input  logic signed [COORD_WIDTH-1:0] p3_x_i,
  input  logic signed [COORD_WIDTH-1:0] p3_y_i,
  input  logic        [T_WIDTH-1:0]     param_t_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o
);

  import crp_pkg::*;

  // accumulator width covers the worst horner intermediate with margin
  localparam int unsigned AW = COORD_WIDTH + AccGuardBits;

  // stage map:
  //   1      coefficients a, b, c
  //   2..3   step 1: (c*t rounded) + b
  //   4..5   step 2: (acc*t rounded) + a
  //   6..7   step 3: (acc*t rounded) + 2*p1 + 1
  //   8      halve, saturate, output register
  logic [PipeDepth-1:0] valid_q;
  logic                 advance;

  // one shared enable: the pipe moves unless the output holds a stalled result
  assign advance    = !(valid_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[PipeDepth-2:0], in_valid_i};
    end
  end

  assign out_valid_o = valid_q[PipeDepth-1];

  // t travels alongside; taps at stage 1, 3 and 5 feed the three multipliers
  logic [T_WIDTH-1:0] t_q [1:5];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      t_q[1] <= param_t_i;
      for (int i = 2; i <= 5; i++) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  // per-axis views of the request and result ports
  logic signed [COORD_WIDTH-1:0] p0_a  [NumAxes];
  logic signed [COORD_WIDTH-1:0] p1_a  [NumAxes];
  logic signed [COORD_WIDTH-1:0] p2_a  [NumAxes];
  logic signed [COORD_WIDTH-1:0] p3_a  [NumAxes];
  logic signed [COORD_WIDTH-1:0] out_a [NumAxes];

  assign p0_a[0] = p0_x_i;
  assign p0_a[1] = p0_y_i;
  assign p1_a[0] = p1_x_i;
  assign p1_a[1] = p1_y_i;
  assign p2_a[0] = p2_x_i;
  assign p2_a[1] = p2_y_i;
  assign p3_a[0] = p3_x_i;
  assign p3_a[1] = p3_y_i;

  assign out_x_o = out_a[0];
  assign out_y_o = out_a[1];

  for (genvar g = 0; g < NumAxes; g++) begin : g_axis
    logic signed [AW-1:0]          a_s1, b_s1, c_s1;
    logic signed [COORD_WIDTH-1:0] p1_s1;
    logic signed [AW-1:0]          a_q2, a_q3;
    logic signed [COORD_WIDTH-1:0] p1_q [2:5];
    logic signed [AW-1:0]          acc1, acc2, sum;
    logic signed [AW-1:0]          p1_twice_plus1;

    crp_coef #(
      .CW (COORD_WIDTH),
      .AW (AW)
    ) u_coef (
      .clk_i (clk_i),
      .en_i  (advance),
      .p0_i  (p0_a[g]),
      .p1_i  (p1_a[g]),
      .p2_i  (p2_a[g]),
      .p3_i  (p3_a[g]),
      .a_o   (a_s1),
      .b_o   (b_s1),
      .c_o   (c_s1),
      .p1_o  (p1_s1)
    );

    // a is needed at stage 3, p1 at stage 5
    always_ff @(posedge clk_i) begin
      if (advance) begin
        a_q2    <= a_s1;
        a_q3    <= a_q2;
        p1_q[2] <= p1_s1;
        for (int i = 3; i <= 5; i++) begin
          p1_q[i] <= p1_q[i-1];
        end
      end
    end

    // 2*p1 + 1 folds the final rounding constant into the last step
    assign p1_twice_plus1 =
      $signed({{(AW-COORD_WIDTH-1){p1_q[5][COORD_WIDTH-1]}}, p1_q[5], 1'b1});

    crp_step #(
      .AW (AW),
      .TW (T_WIDTH)
    ) u_step1 (
      .clk_i    (clk_i),
      .en_i     (advance),
      .acc_i    (c_s1),
      .t_i      (t_q[1]),
      .addend_i (b_s1),
      .res_o    (acc1)
    );

    crp_step #(
      .AW (AW),
      .TW (T_WIDTH)
    ) u_step2 (
      .clk_i    (clk_i),
      .en_i     (advance),
      .acc_i    (acc1),
      .t_i      (t_q[3]),
      .addend_i (a_q3),
      .res_o    (acc2)
    );

    crp_step #(
      .AW (AW),
      .TW (T_WIDTH)
    ) u_step3 (
      .clk_i    (clk_i),
      .en_i     (advance),
      .acc_i    (acc2),
      .t_i      (t_q[5]),
      .addend_i (p1_twice_plus1),
      .res_o    (sum)
    );

    crp_final #(
      .CW (COORD_WIDTH),
      .AW (AW)
    ) u_final (
      .clk_i (clk_i),
      .en_i  (advance),
      .sum_i (sum),
      .res_o (out_a[g])
    );
  end

endmodule

@@ src/crp_coef.sv @@
`timescale 1ns / 1ps
// polynomial coefficient stage for one axis: a, b, c and p1 registered
// depends on nothing outside this file

module crp_coef #(
  parameter int unsigned CW = 24,
  parameter int unsigned AW = 30
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] p0_i,
  input  logic signed [CW-1:0] p1_i,
  input  logic signed [CW-1:0] p2_i,
  input  logic signed [CW-1:0] p3_i,
  output logic signed [AW-1:0] a_o,
  output logic signed [AW-1:0] b_o,
  output logic signed [AW-1:0] c_o,
  output logic signed [CW-1:0] p1_o
);

  logic signed [AW-1:0] p0_e, p1_e, p2_e, p3_e;
  logic signed [AW-1:0] a_d, b_d, c_d;
  logic signed [AW-1:0] a_q, b_q, c_q;
  logic signed [CW-1:0] p1_q;

  assign p0_e = AW'(p0_i);
  assign p1_e = AW'(p1_i);
  assign p2_e = AW'(p2_i);
  assign p3_e = AW'(p3_i);

  // a = p2 - p0, b = 2p0 - 5p1 + 4p2 - p3, c = -p0 + 3p1 - 3p2 + p3
  always_comb begin
    a_d = p2_e - p0_e;
    b_d = (p0_e <<< 1) - ((p1_e <<< 2) + p1_e) + (p2_e <<< 2) - p3_e;
    c_d = ((p1_e <<< 1) + p1_e) - ((p2_e <<< 1) + p2_e) + p3_e - p0_e;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      b_q  <= b_d;
      c_q  <= c_d;
      p1_q <= p1_i;
    end
  end

  assign a_o  = a_q;
  assign b_o  = b_q;
  assign c_o  = c_q;
  assign p1_o = p1_q;

endmodule

@@ src/crp_step.sv @@
`timescale 1ns / 1ps
// one horner step: multiply by t, then round half up, drop t fraction, add
// two register stages; depends on nothing outside this file

module crp_step #(
  parameter int unsigned AW = 30,
  parameter int unsigned TW = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] acc_i,
  input  logic        [TW-1:0] t_i,
  input  logic signed [AW-1:0] addend_i,
  output logic signed [AW-1:0] res_o
);

  localparam int unsigned PW = AW + TW + 1;
  localparam logic signed [PW-1:0] RndHalf = PW'(1) <<< (TW - 1);

  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [AW-1:0] addend_q;
  logic signed [PW-1:0] rnd;
  logic signed [AW-1:0] shifted;
  logic signed [AW-1:0] res_d, res_q;

  // exact product, t treated as a non-negative value
  assign prod_d = PW'(acc_i) * PW'($signed({1'b0, t_i}));

  // the scaled value never exceeds the accumulator magnitude, so it fits in AW
  always_comb begin
    rnd     = prod_q + RndHalf;
    shifted = AW'(rnd >>> TW);
    res_d   = shifted + addend_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      addend_q <= addend_i;
      res_q    <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ src/crp_final.sv @@
`timescale 1ns / 1ps
// final halving (floor) and saturation to the coordinate range
// depends on nothing outside this file

module crp_final #(
  parameter int unsigned CW = 24,
  parameter int unsigned AW = 30
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] sum_i,
  output logic signed [CW-1:0] res_o
);

  localparam logic signed [AW-1:0] SatHi = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] SatLo = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [AW-1:0] half;
  logic signed [CW-1:0] res_d, res_q;

  always_comb begin
    half = sum_i >>> 1;
    if (half > SatHi) begin
      res_d = SatHi[CW-1:0];
    end else if (half < SatLo) begin
      res_d = SatLo[CW-1:0];
    end else begin
      res_d = half[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ dv/tb_catmull_rom_point_eval_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for catmull_rom_point_eval_top: directed and random requests vs. an in-bench predictor
// depends on crp_pkg and the catmull_rom_point_eval_top rtl

module tb_catmull_rom_point_eval_top;

  import crp_pkg::*;

  localparam int unsigned CoordW     = 24;
  localparam int unsigned TW         = 16;
  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned MaxWait    = 17;
  localparam int unsigned RandReqs   = 580;
  localparam int unsigned MaxReports = 10;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // one segment evaluation request plus the idle time the sender takes after it
  typedef struct {
    logic signed [CoordW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    logic        [TW-1:0]     t;
    int unsigned              gap;
  } seg_req_t;

  typedef struct {
    logic signed [CoordW-1:0] x, y;
  } point_t;

  // clock, reset and every block input start at known values
  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [CoordW-1:0] p0_x_i = '0, p0_y_i = '0, p1_x_i = '0, p1_y_i = '0;
  logic signed [CoordW-1:0] p2_x_i = '0, p2_y_i = '0, p3_x_i = '0, p3_y_i = '0;
  logic        [TW-1:0]     param_t_i = '0;

  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [CoordW-1:0] out_x_o, out_y_o;

  seg_req_t    pending[$];    // requests not yet presented to the block
  point_t      points_due[$]; // predicted points, oldest first
  int unsigned mismatches   = 0;
  int unsigned points_seen  = 0;
  int unsigned reqs_queued  = 0;
  int unsigned send_wait    = 0;
  int unsigned hold_left    = 0;
  logic        req_taken    = 1'b0;
  logic        point_taken  = 1'b0;

  catmull_rom_point_eval_top #(
    .COORD_WIDTH(CoordW),
    .T_WIDTH    (TW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .p0_x_i     (p0_x_i),
    .p0_y_i     (p0_y_i),
    .p1_x_i     (p1_x_i),
    .p1_y_i     (p1_y_i),
    .p2_x_i     (p2_x_i),
    .p2_y_i     (p2_y_i),
    .p3_x_i     (p3_x_i),
    .p3_y_i     (p3_y_i),
    .param_t_i  (param_t_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // acc * t / 2^TW, rounded half toward +inf; >>> on a signed longint floors
  function automatic longint scale_by_t(longint acc, longint tv);
    return (acc * tv + (longint'(1) <<< (TW - 1))) >>> TW;
  endfunction

  // one axis of the segment: horner form of the cubic, halved, then clamped
  function automatic logic signed [CoordW-1:0] spline_axis(
    logic signed [CoordW-1:0] q0, logic signed [CoordW-1:0] q1,
    logic signed [CoordW-1:0] q2, logic signed [CoordW-1:0] q3,
    logic        [TW-1:0]     t
  );
    longint v0, v1, v2, v3, tv, lin, quad, cub, acc, r;
    v0   = longint'(q0);
    v1   = longint'(q1);
    v2   = longint'(q2);
    v3   = longint'(q3);
    tv   = longint'({48'd0, t});
    lin  = v2 - v0;
    quad = 2 * v0 - 5 * v1 + 4 * v2 - v3;
    cub  = -v0 + 3 * v1 - 3 * v2 + v3;
    acc  = scale_by_t(cub, tv) + quad;
    acc  = scale_by_t(acc, tv) + lin;
    acc  = scale_by_t(acc, tv);
    r    = (2 * v1 + acc + 1) >>> 1;
    if (r > longint'(CoordMax)) r = longint'(CoordMax);
    if (r < longint'(CoordMin)) r = longint'(CoordMin);
    return r[CoordW-1:0];
  endfunction

  function automatic point_t curve_point(seg_req_t s);
    point_t p;
    p.x = spline_axis(s.p0x, s.p1x, s.p2x, s.p3x, s.t);
    p.y = spline_axis(s.p0y, s.p1y, s.p2y, s.p3y, s.t);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // wait length for one request or result; quiet stretches never idle
  function automatic int unsigned draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MaxWait);
  endfunction

  task automatic queue_req(
    logic signed [CoordW-1:0] p0x, logic signed [CoordW-1:0] p0y,
    logic signed [CoordW-1:0] p1x, logic signed [CoordW-1:0] p1y,
    logic signed [CoordW-1:0] p2x, logic signed [CoordW-1:0] p2y,
    logic signed [CoordW-1:0] p3x, logic signed [CoordW-1:0] p3y,
    logic        [TW-1:0]     t
  );
    seg_req_t s;
    s = '{p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, t, 0};
    // every 200 requests, a back-to-back stretch of 60
    s.gap = draw_wait((reqs_queued % 200) >= 140);
    pending.push_back(s);
    reqs_queued++;
  endtask

  // kinds: 0 full range, 1 near a shared base (smooth curve), 2 corner values,
  // otherwise moderate magnitudes
  function automatic logic signed [CoordW-1:0] pick_coord(
    int unsigned kind, logic signed [CoordW-1:0] base
  );
    case (kind)
      0: return CoordW'($urandom());
      1: return base + CoordW'(int'($urandom_range(0, 8191)) - 4096);
      2: begin
        case ($urandom_range(0, 3))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return CoordW'(int'($urandom_range(0, 4194303)) - 2097152);
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: begin
        case ($urandom_range(0, 2))
          0: return TW'(1);
          1: return {1'b1, {(TW-1){1'b0}}};
          default: return {1'b0, {(TW-1){1'b1}}};
        endcase
      end
      default: return TW'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: changes inputs at the falling edge, holds while stalled
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    seg_req_t s;
    logic     drive_v;
    drive_v = in_valid_i;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      drive_v = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending.size() > 0) begin
        s = pending.pop_front();
        p0_x_i    <= s.p0x;
        p0_y_i    <= s.p0y;
        p1_x_i    <= s.p1x;
        p1_y_i    <= s.p1y;
        p2_x_i    <= s.p2x;
        p2_y_i    <= s.p2y;
        p3_x_i    <= s.p3x;
        p3_y_i    <= s.p3y;
        param_t_i <= s.t;
        drive_v   = 1'b1;
        send_wait = s.gap;
      end
    end
    // single assignment per edge so a back-to-back request keeps valid high
    in_valid_i <= drive_v;
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: a fresh hold length per result, counted down
  // only while a result is waiting; every 200 results, 50 go through unstalled
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic hold;
    if (point_taken) hold_left = draw_wait((points_seen % 200) >= 150);
    hold = (hold_left > 0);
    if (hold && out_valid_o) hold_left--;
    out_stall_i <= hold;
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    seg_req_t s;
    point_t   want;
    if (!rst_ni) begin
      req_taken   <= 1'b0;
      point_taken <= 1'b0;
    end else begin
      req_taken   <= in_valid_i && !in_stall_o;
      point_taken <= out_valid_o && !out_stall_i;
      // check the outgoing point before booking this edge's request
      if (out_valid_o && !out_stall_i) begin
        points_seen++;
        if (points_due.size() == 0) begin
          flag_error($sformatf("unexpected point x=%0d y=%0d", out_x_o, out_y_o));
        end else begin
          want = points_due.pop_front();
          if (out_x_o !== want.x)
            flag_error($sformatf("point %0d x: expected %0d, got %0d",
                                 points_seen, want.x, out_x_o));
          if (out_y_o !== want.y)
            flag_error($sformatf("point %0d y: expected %0d, got %0d",
                                 points_seen, want.y, out_y_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        s = '{p0_x_i, p0_y_i, p1_x_i, p1_y_i, p2_x_i, p2_y_i, p3_x_i, p3_y_i,
              param_t_i, 0};
        points_due.push_back(curve_point(s));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [CoordW-1:0] base;
    int unsigned              kind;

    // directed: zero, t = 0 returns p1, all-max / all-min, alternating
    // extremes that drive the result into saturation, bit patterns, a line
    queue_req('0, '0, '0, '0, '0, '0, '0, '0, '0);
    queue_req(24'sd1000, -24'sd2000, 24'sd12345, -24'sd777, CoordMax, CoordMin,
              24'sd5, 24'sd6, '0);
    queue_req(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax,
              CoordMax, CoordMin, '0);
    queue_req(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
              CoordMax, CoordMax, '1);
    queue_req(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
              CoordMin, CoordMin, '1);
    queue_req(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax,
              CoordMax, CoordMin, 16'h8000);
    queue_req(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin,
              CoordMin, CoordMax, 16'h8000);
    queue_req(CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax,
              CoordMin, CoordMin, 16'h4000);
    queue_req(CoordMax, CoordMax, CoordMin, CoordMin, CoordMin, CoordMin,
              CoordMax, CoordMax, 16'hc000);
    queue_req(CoordMin, CoordMin, CoordMax, CoordMax, CoordMin, CoordMin,
              CoordMax, CoordMax, '1);
    queue_req(24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555,
              24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 16'h5555);
    queue_req(24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa,
              24'sh555555, 24'shaaaaaa, 24'sh555555, 16'haaaa);
    queue_req('0, '0, 24'sd256, -24'sd256, 24'sd512, -24'sd512, 24'sd768, -24'sd768,
              16'h4000);
    queue_req(24'sd3, -24'sd3, -24'sd1, -24'sd1, -24'sd2, 24'sd2, 24'sd1, -24'sd5,
              16'h8000);
    queue_req(24'sd100, 24'sd100, 24'sd200, 24'sd200, 24'sd300, 24'sd300,
              24'sd400, 24'sd400, TW'(1));
    queue_req(CoordMax - 24'sd10, CoordMin + 24'sd10, CoordMax, CoordMin, CoordMax,
              CoordMin, CoordMax - 24'sd10, CoordMin + 24'sd10, 16'h7fff);
    queue_req(-24'sd1, -24'sd1, '0, '0, -24'sd1, -24'sd1, '0, '0, '1);

    // random: mostly independent segments with mixed coordinate styles
    repeat (RandReqs) begin
      kind = $urandom_range(0, 9);
      kind = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind == 6) ? 2 : 3;
      base = CoordW'(int'($urandom_range(0, 2097151)) - 1048576);
      queue_req(pick_coord(kind, base), pick_coord(kind, base),
                pick_coord(kind, base), pick_coord(kind, base),
                pick_coord(kind, base), pick_coord(kind, base),
                pick_coord(kind, base), pick_coord(kind, base), pick_t());
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests taken and every predicted point returned
    while (pending.size() != 0 || in_valid_i || points_due.size() != 0)
      @(posedge clk_i);
    // a few more pipeline lengths to catch stray results
    repeat (2 * PipeDepth + 4) @(posedge clk_i);

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run of about 600 requests
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
